>>> hw/rtl/rolling_hash_substring_match_defines.svh
// Assertion macros for the substring matcher checker
`ifndef ROLLING_HASH_SUBSTRING_MATCH_DEFINES_SVH
`define ROLLING_HASH_SUBSTRING_MATCH_DEFINES_SVH

// same-cycle implication under reset
`define RHSM_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("rhsm checker: same-cycle property failed");

// next-cycle implication under reset
`define RHSM_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("rhsm checker: next-cycle property failed");

`endif

>>> hw/rtl/rhsm_pkg.sv
// Shared types and constants for the substring matcher
package rhsm_pkg;

	localparam logic [1:0] REG_PATTERN_BYTES = 2'd0;
	localparam logic [1:0] REG_PATTERN_LEN   = 2'd1;

	localparam logic [31:0] POS_MAX = 32'hFFFF_FFFF;

	typedef struct packed {
		logic [63:0] pattern;
		logic [3:0]  act_len;
	} rhsm_cfg_t;

endpackage

>>> hw/rtl/rhsm_cell.sv
// One window cell: holds a text byte, compares its next value, hands it on
module rhsm_cell (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       shift_en,
	input  logic       kill,
	input  logic       active,
	input  logic [7:0] din,
	input  logic [7:0] expected,
	output logic [7:0] dout,
	output logic       eq
);

	logic [7:0] store_q;
	logic [7:0] nxt;

	assign nxt  = kill ? 8'd0 : din;
	assign eq   = !active || (nxt == expected);
	assign dout = store_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			store_q <= 8'd0;
		end else if (shift_en) begin
			store_q <= nxt;
		end
	end

endmodule

>>> hw/rtl/rhsm_cfg.sv
// Configuration registers and active pattern length
module rhsm_cfg import rhsm_pkg::*; #(
	parameter int MAX_PAT = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	input  logic [1:0]  cfg_index,
	input  logic [63:0] cfg_data,
	output rhsm_cfg_t   cfg
);

	localparam logic [3:0] MaxLen = 4'(MAX_PAT);

	logic [63:0] pattern_q;
	logic [3:0]  len_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pattern_q <= 64'd0;
			len_q     <= 4'd1;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_PATTERN_BYTES: pattern_q <= cfg_data;
				REG_PATTERN_LEN:   len_q     <= cfg_data[3:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		cfg.pattern = pattern_q;
		if (len_q == 4'd0) begin
			cfg.act_len = 4'd1;
		end else if (len_q > MaxLen) begin
			cfg.act_len = MaxLen;
		end else begin
			cfg.act_len = len_q;
		end
	end

endmodule

>>> hw/rtl/rolling_hash_substring_match.sv
// Streaming substring matcher: row of window cells with registered result
// The result for an accepted text byte is registered and valid in the cycle after.
// Throughput: one byte per cycle while in_stall is low; cells shift and compare.
// Stalls on the result side hold the input side through in_stall.
// Reset clears the window, the position counter and the result valid;
// pattern resets to zero and length to one.
module rolling_hash_substring_match import rhsm_pkg::*; #(
	parameter int MAX_PAT = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [63:0] cfg_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  text_byte,
	input  logic        text_start,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        match_found,
	output logic [31:0] match_start
);

	rhsm_cfg_t cfg;

	logic [7:0]         tap [MAX_PAT];
	logic [MAX_PAT-1:0] eq;
	logic               accept;
	logic [31:0]        bytes_seen_q;
	logic [31:0]        pos;
	logic [31:0]        span;
	logic               hit;
	logic               out_valid_q;
	logic               match_found_q;
	logic [31:0]        match_start_q;

	assign cfg_ready = 1'b1;

	rhsm_cfg #(.MAX_PAT(MAX_PAT)) u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	assign in_stall = out_valid_q && out_stall;
	assign accept   = in_valid && !in_stall;

	for (genvar j = 0; j < MAX_PAT; j++) begin : g_cell
		logic [3:0] sel;
		logic [7:0] expected;
		logic [7:0] din;
		logic       kill;

		assign sel      = cfg.act_len - 4'd1 - 4'(j);
		assign expected = cfg.pattern[{sel[2:0], 3'b000} +: 8];

		if (j == 0) begin : g_head
			assign din  = text_byte;
			assign kill = 1'b0;
		end else begin : g_body
			assign din  = tap[j-1];
			assign kill = text_start;
		end

		rhsm_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.shift_en (accept),
			.kill     (kill),
			.active   (cfg.act_len > 4'(j)),
			.din      (din),
			.expected (expected),
			.dout     (tap[j]),
			.eq       (eq[j])
		);
	end

	assign pos  = text_start ? 32'd0 : bytes_seen_q;
	assign span = {28'd0, cfg.act_len - 4'd1};
	assign hit  = (&eq) && (pos >= span);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bytes_seen_q <= 32'd0;
			out_valid_q  <= 1'b0;
		end else begin
			if (accept) begin
				bytes_seen_q <= (pos == POS_MAX) ? pos : pos + 32'd1;
			end
			if (accept) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			match_found_q <= hit;
			match_start_q <= hit ? pos - span : 32'd0;
		end
	end

	assign out_valid   = out_valid_q;
	assign match_found = match_found_q;
	assign match_start = match_start_q;

endmodule

>>> hw/rtl/rhsm_checker.sv
// Port-level checker for the substring matcher, bound to the top level
`include "rolling_hash_substring_match_defines.svh"

module rhsm_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_stall,
	input logic        out_valid,
	input logic        out_stall,
	input logic        match_found,
	input logic [31:0] match_start
);

	`RHSM_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid)
	`RHSM_ASSERT_NEXT(a_out_stable, out_valid && out_stall, $stable(match_found) && $stable(match_start))
	`RHSM_ASSERT_NOW(a_miss_zero, out_valid && !match_found, match_start == 32'd0)
	`RHSM_ASSERT_NEXT(a_one_cycle, in_valid && !in_stall, out_valid)

endmodule

bind rolling_hash_substring_match rhsm_checker u_rhsm_checker (.*);

>>> verif/tb_rolling_hash_substring_match.sv
`timescale 1ns / 100ps
// Self-checking testbench for the substring matcher against a byte-compare predictor
module tb_rolling_hash_substring_match import rhsm_pkg::*; ();

	localparam int PAT_DEPTH = 8;
	localparam int PHASES = 12;
	localparam int PHASE_BYTES = 95;
	localparam logic [1:0] REG_SPARE_A = 2'd2;
	localparam logic [1:0] REG_SPARE_B = 2'd3;

	typedef struct packed {
		logic        found;
		logic [31:0] start;
	} match_rec_t;

	logic        clk;
	logic        arst_n;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [1:0]  cfg_index;
	logic [63:0] cfg_data;
	logic        in_valid;
	logic        in_stall;
	logic [7:0]  text_byte;
	logic        text_start;
	logic        out_valid;
	logic        out_stall;
	logic        match_found;
	logic [31:0] match_start;

	match_rec_t  due_matches[$];
	logic [7:0]  win_bytes[PAT_DEPTH];
	logic [31:0] text_pos;
	logic [63:0] cur_pattern;
	logic [3:0]  cur_len;
	bit          calm;
	int          faults;
	int          bytes_sent;
	int          results_seen;
	int          hits_seen;
	int          settings_loaded;

	rolling_hash_substring_match #(.MAX_PAT(PAT_DEPTH)) uut (.*);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("Verification failed");
		$finish;
	end

	function automatic int active_len();
		if (cur_len == 4'd0) return 1;
		if (cur_len > PAT_DEPTH) return PAT_DEPTH;
		return int'(cur_len);
	endfunction

	// advance the window by one byte and decide whether its tail equals the pattern
	function automatic match_rec_t scan_byte(input logic [7:0] b, input logic s);
		match_rec_t r;
		int n;
		logic [31:0] pos;
		n = active_len();
		if (s) begin
			foreach (win_bytes[k]) win_bytes[k] = 8'h00;
			text_pos = 32'd0;
		end
		pos = text_pos;
		for (int k = PAT_DEPTH - 1; k > 0; k--) win_bytes[k] = win_bytes[k - 1];
		win_bytes[0] = b;
		if (text_pos != POS_MAX) text_pos = text_pos + 32'd1;
		r.found = 1'b0;
		r.start = 32'd0;
		if (64'(pos) + 64'd1 >= 64'(n)) begin
			r.found = 1'b1;
			for (int k = 0; k < n; k++)
				if (win_bytes[n - 1 - k] != cur_pattern[8 * k +: 8]) r.found = 1'b0;
			if (r.found) r.start = pos + 32'd1 - 32'(n);
		end
		return r;
	endfunction

	function automatic void note_fault(input string what, input logic [31:0] want,
			input logic [31:0] got);
		faults++;
		if (faults <= 10)
			$display("MISMATCH %s: expected %0h, got %0h at %0t", what, want, got, $realtime);
	endfunction

	always @(posedge clk) begin : check_results
		match_rec_t want;
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				results_seen++;
				if (due_matches.size() == 0) begin
					note_fault("result with no request pending", 32'd0, 32'(match_found));
				end else begin
					want = due_matches.pop_front();
					if (match_found !== want.found)
						note_fault("match_found", 32'(want.found), 32'(match_found));
					if (match_start !== want.start)
						note_fault("match_start", want.start, match_start);
					if (want.found) hits_seen++;
				end
			end
			out_stall <= !calm && ($urandom_range(0, 99) < 19);
		end
	end

	task automatic write_reg(input logic [1:0] idx, input logic [63:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			REG_PATTERN_BYTES: cur_pattern = data;
			REG_PATTERN_LEN:   cur_len = data[3:0];
			default: ;
		endcase
	endtask

	// upper bits of the length word are noise and must be ignored
	task automatic load_pattern(input logic [63:0] pattern, input logic [3:0] len);
		write_reg(REG_PATTERN_BYTES, pattern);
		write_reg(REG_PATTERN_LEN, ({$urandom(), $urandom()} & ~64'hF) | 64'(len));
		cfg_valid <= 1'b0;
		settings_loaded++;
	endtask

	task automatic send_byte(input logic [7:0] b, input logic s);
		if (!calm) begin
			while ($urandom_range(0, 99) < 19) begin
				in_valid <= 1'b0;
				@(posedge clk);
			end
		end
		in_valid   <= 1'b1;
		text_byte  <= b;
		text_start <= s;
		do @(posedge clk); while (in_stall);
		due_matches.push_back(scan_byte(b, s));
		bytes_sent++;
	endtask

	// hold the sender until every request has its result
	task automatic drain();
		in_valid <= 1'b0;
		while (due_matches.size() != 0) @(posedge clk);
	endtask

	task automatic test_reset_state();
		send_byte(8'h00, 1'b0);
		send_byte(8'hFF, 1'b0);
		send_byte(8'h00, 1'b1);
		drain();
	endtask

	task automatic test_ignored_index();
		write_reg(REG_SPARE_A, {$urandom(), $urandom()});
		write_reg(REG_SPARE_B, {$urandom(), $urandom()});
		cfg_valid <= 1'b0;
		send_byte(8'h00, 1'b0);
		drain();
	endtask

	task automatic test_unused_bytes();
		load_pattern({$urandom(), 8'hC3, 24'h636261}, 4'd3);
		send_byte("a", 1'b1);
		send_byte("b", 1'b0);
		send_byte("c", 1'b0);
		send_byte("a", 1'b0);
		send_byte("b", 1'b0);
		send_byte("c", 1'b0);
		drain();
	endtask

	task automatic test_window_fill();
		send_byte("a", 1'b0);
		send_byte("b", 1'b0);
		send_byte("c", 1'b1);
		drain();
	endtask

	task automatic test_length_change();
		load_pattern(cur_pattern, 4'd1);
		send_byte("a", 1'b0);
		drain();
		load_pattern(cur_pattern, 4'd0);
		send_byte("a", 1'b0);
		drain();
	endtask

	task automatic test_length_limits();
		load_pattern('1, 4'd15);
		send_byte(8'hFF, 1'b1);
		repeat (8) send_byte(8'hFF, 1'b0);
		drain();
	endtask

	task automatic test_random_text();
		int n;
		int pick;
		int bad;
		int count;
		logic [63:0] p;
		logic [3:0]  len;
		logic [7:0]  b;
		logic [7:0]  s0;
		logic [7:0]  s1;
		for (int phase = 0; phase < PHASES; phase++) begin
			case (phase)
				0:       begin p = '0; len = 4'd1; end
				1:       begin p = '1; len = 4'd8; end
				2:       begin p = {$urandom(), $urandom()}; len = 4'd0; end
				3:       begin p = {$urandom(), $urandom()}; len = 4'd15; end
				default: begin
					p = {$urandom(), $urandom()};
					len = 4'($urandom_range(0, 15));
				end
			endcase
			if (phase % 3 == 2) begin
				s0 = 8'($urandom_range(0, 255));
				s1 = 8'($urandom_range(0, 255));
				for (int k = 0; k < PAT_DEPTH; k++) p[8 * k +: 8] = $urandom_range(0, 1) ? s0 : s1;
			end
			if (phase % 4 == 3) write_reg(REG_SPARE_A, {$urandom(), $urandom()});
			load_pattern(p, len);
			calm = (phase == 5);
			n = active_len();
			count = 0;
			while (count < PHASE_BYTES) begin
				pick = $urandom_range(0, 99);
				if (pick < 45) begin
					bad = ($urandom_range(0, 3) == 0) ? $urandom_range(0, n - 1) : -1;
					for (int k = 0; k < n; k++) begin
						b = cur_pattern[8 * k +: 8];
						if (k == bad) b = b ^ (8'h01 << $urandom_range(0, 7));
						send_byte(b, k == 0 && $urandom_range(0, 9) == 0);
						count++;
					end
				end else if (pick < 80) begin
					send_byte(cur_pattern[8 * $urandom_range(0, n - 1) +: 8],
						$urandom_range(0, 99) < 3);
					count++;
				end else begin
					send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 99) < 3);
					count++;
				end
			end
			drain();
		end
		calm = 1'b0;
	endtask

	initial begin
		arst_n     <= 1'b0;
		cfg_valid  <= 1'b0;
		cfg_index  <= REG_PATTERN_BYTES;
		cfg_data   <= '0;
		in_valid   <= 1'b0;
		text_byte  <= 8'h00;
		text_start <= 1'b0;
		foreach (win_bytes[k]) win_bytes[k] = 8'h00;
		text_pos    = 32'd0;
		cur_pattern = '0;
		cur_len     = 4'd1;
		calm        = 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		test_reset_state();
		test_ignored_index();
		test_unused_bytes();
		test_window_fill();
		test_length_change();
		test_length_limits();
		test_random_text();
		drain();
		repeat (4) @(posedge clk);
		if (due_matches.size() != 0)
			note_fault("requests left without result", 32'd0, 32'(due_matches.size()));
		$display("Covered %0d text bytes under %0d pattern settings (lengths 0 to 15).",
			bytes_sent, settings_loaded);
		$display("Checked %0d results, %0d of them matches.", results_seen, hits_seen);
		if (faults == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule
